/* hdl/alm_pkg.sv */
// Shared types and constants for the autoranging light meter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package alm_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int RF_W        = 24;
    localparam int GAIN_W      = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int LUX_W       = 16;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam int PROD1_W     = 23;
    localparam int PROD2_W     = 47;
    localparam int DIV_W       = 31;

    // microvolts per converter count: floor(5000000 / 4095)
    localparam logic [10:0] UV_PER_COUNT = 11'd1221;

    localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_READING = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RF_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RF_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd4;

    localparam logic [SAMPLE_W-1:0] OFFSET_RST      = 12'd36;
    localparam logic [SAMPLE_W-1:0] MAX_READING_RST = 12'd3849;
    localparam logic [RF_W-1:0]     RF_HIGH_RST     = 24'd184600;
    localparam logic [RF_W-1:0]     RF_LOW_RST      = 24'd672;
    localparam logic [GAIN_W-1:0]   GAIN_RST        = 24'd873595;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHECK,
        ST_MUL,
        ST_LUX_START,
        ST_LUX_WAIT,
        ST_LUX_FIN,
        ST_DONE
    } alm_state_t;

    typedef struct packed {
        logic capture;
        logic accumulate;
        logic avg_latch;
        logic check;
        logic mul2;
        logic lux_start;
        logic lux_finish;
        logic load_out;
    } alm_cmd_t;

    typedef struct packed {
        logic full;
        logic overrange;
        logic rf_zero;
        logic div_done;
        logic out_free;
    } alm_status_t;

endpackage

/* hdl/alm_divider.sv */
// Restoring serial divider, one quotient bit per cycle.
// Uses alm_pkg for widths.
`timescale 1ns / 1ps

module alm_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [alm_pkg::DIV_W-1:0]   dividend,
    input  logic [alm_pkg::RF_W-1:0]    divisor,
    output logic                        done,
    output logic [alm_pkg::DIV_W-1:0]   quotient
);
    import alm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RF_W:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [RF_W:0]     rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg[RF_W-1:0], quo_reg[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        !(start && busy_reg))
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");
`endif

endmodule

/* hdl/alm_datapath.sv */
// Datapath: config registers, accumulator, multipliers, lux divider, output register.
// Uses alm_pkg and alm_divider; driven by alm_ctrl through alm_cmd_t.
`timescale 1ns / 1ps

module alm_datapath #(
    parameter int SAMPLES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  alm_pkg::alm_cmd_t                 cmd,
    output alm_pkg::alm_status_t              status,
    input  logic [alm_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              cfg_valid,
    input  logic [alm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [alm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [alm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tuser
);
    import alm_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam int SUM_W = $clog2(SAMPLES * 4096);

    // sum / SAMPLES as a multiply by a rounded-up reciprocal; exact for every sum
    // below 2**SUM_W
    localparam int     AVG_SH     = SUM_W + $clog2(SAMPLES);
    localparam longint AVG_MUL    = ((longint'(1) << AVG_SH) + longint'(SAMPLES) - 1)
                                    / longint'(SAMPLES);
    localparam int     AVG_PROD_W = 2 * SUM_W + 1;

    logic [SAMPLE_W-1:0] offset_reg, max_reading_reg;
    logic [RF_W-1:0]     rf_high_reg, rf_low_reg;
    logic [GAIN_W-1:0]   gain_reg;

    logic [SAMPLE_W-1:0] sample_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]    sum_reg, sum_plus;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic                range_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [SAMPLE_W-1:0] net;
    logic [PROD1_W-1:0]  prod1_reg;
    logic [PROD2_W-1:0]  prod2_reg;
    logic [RF_W-1:0]     rf_sel;

    logic                res_valid_reg, res_sat_reg, res_used_reg;
    logic [LUX_W-1:0]    res_lux_reg;

    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;

    logic                div_start, div_done;
    logic [DIV_W-1:0]    div_dividend, div_quotient;
    logic [RF_W-1:0]     div_divisor;
    logic                lux_over;

    assign sum_plus = sum_reg + SUM_W'(sample_reg);
    assign avg_prod = AVG_PROD_W'(sum_plus) * AVG_PROD_W'(AVG_MUL);
    assign net      = (avg_reg > offset_reg) ? (avg_reg - offset_reg) : '0;
    assign rf_sel   = range_reg ? rf_low_reg : rf_high_reg;
    assign lux_over = (div_quotient[DIV_W-1:LUX_W] != '0);

    assign div_start    = cmd.lux_start;
    assign div_dividend = prod2_reg[PROD2_W-1:16];
    assign div_divisor  = rf_sel;

    alm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        status.full      = (count_reg == CNT_W'(SAMPLES - 1));
        status.overrange = !range_reg && (avg_reg > max_reading_reg);
        status.rf_zero   = (rf_sel == '0);
        status.div_done  = div_done;
        status.out_free  = !m_tvalid_reg || m_tready;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg      <= OFFSET_RST;
            max_reading_reg <= MAX_READING_RST;
            rf_high_reg     <= RF_HIGH_RST;
            rf_low_reg      <= RF_LOW_RST;
            gain_reg        <= GAIN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_OFFSET:      offset_reg      <= cfg_data[SAMPLE_W-1:0];
                REG_MAX_READING: max_reading_reg <= cfg_data[SAMPLE_W-1:0];
                REG_RF_HIGH:     rf_high_reg     <= cfg_data[RF_W-1:0];
                REG_RF_LOW:      rf_low_reg      <= cfg_data[RF_W-1:0];
                REG_GAIN:        gain_reg        <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // measurement state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            range_reg <= 1'b0;
        end else begin
            if (cmd.accumulate) begin
                if (status.full) begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                end else begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_plus;
                end
            end
            if (cmd.check && status.overrange) begin
                range_reg <= 1'b1;
            end
            if (cmd.lux_finish) begin
                range_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
        if (cmd.avg_latch) begin
            avg_reg <= avg_prod[AVG_SH +: SAMPLE_W];
        end
        if (cmd.check) begin
            prod1_reg <= PROD1_W'(net) * PROD1_W'(UV_PER_COUNT);
        end
        if (cmd.mul2) begin
            prod2_reg <= PROD2_W'(prod1_reg) * PROD2_W'(gain_reg);
        end
        if (cmd.accumulate) begin
            res_valid_reg <= 1'b0;
            res_lux_reg   <= '0;
            res_sat_reg   <= 1'b0;
            res_used_reg  <= 1'b0;
        end
        if (cmd.lux_finish) begin
            res_valid_reg <= 1'b1;
            res_used_reg  <= range_reg;
            if (status.rf_zero || lux_over) begin
                res_lux_reg <= LUX_MAX;
                res_sat_reg <= 1'b1;
            end else begin
                res_lux_reg <= div_quotient[LUX_W-1:0];
                res_sat_reg <= 1'b0;
            end
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {5'd0, res_used_reg, res_sat_reg, res_lux_reg, range_reg};
            m_tuser_reg <= res_valid_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < CNT_W'(SAMPLES))
        else $error("sample count reached SAMPLES");
    a_no_lux_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg) |-> (m_tdata_reg[18:1] == '0))
        else $error("lux fields set without a completed measurement");
    a_high_after_lux: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg) |-> !m_tdata_reg[0])
        else $error("range not returned to high gain after a measurement");
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("output register overwritten");
`endif

endmodule

/* hdl/alm_ctrl.sv */
// Controller state machine sequencing accumulate, average, multiply and divide steps.
// Uses alm_pkg; talks to alm_datapath through alm_cmd_t / alm_status_t.
`timescale 1ns / 1ps

module alm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  alm_pkg::alm_status_t  status,
    output alm_pkg::alm_cmd_t     cmd
);
    import alm_pkg::*;

    alm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_ACC;
            ST_ACC:       state_next = status.full ? ST_CHECK : ST_DONE;
            ST_CHECK:     state_next = status.overrange ? ST_DONE : ST_MUL;
            ST_MUL:       state_next = ST_LUX_START;
            ST_LUX_START: state_next = status.rf_zero ? ST_LUX_FIN : ST_LUX_WAIT;
            ST_LUX_WAIT:  if (status.div_done) state_next = ST_LUX_FIN;
            ST_LUX_FIN:   state_next = ST_DONE;
            ST_DONE:      if (status.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_ACC: begin
                cmd.accumulate = 1'b1;
                cmd.avg_latch  = status.full;
            end
            ST_CHECK:     cmd.check      = 1'b1;
            ST_MUL:       cmd.mul2       = 1'b1;
            ST_LUX_START: cmd.lux_start  = !status.rf_zero;
            ST_LUX_FIN:   cmd.lux_finish = 1'b1;
            ST_DONE:      cmd.load_out   = status.out_free;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("input accepted outside idle");
    a_avg_follows_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.avg_latch |=> (state_reg == ST_CHECK))
        else $error("average latch without check state");
    a_finish_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lux_finish |=> (state_reg == ST_DONE))
        else $error("lux finish not followed by result load");
`endif

endmodule

/* hdl/autorange_light_meter.sv */
// Top level of the autoranging light meter: controller plus datapath.
// Depends on alm_pkg, alm_ctrl, alm_datapath, alm_divider.
//
//  channel | dir | handshake             | payload
//  s_      | in  | s_tvalid / s_tready   | s_tdata: sample[11:0]
//  m_      | out | m_tvalid / m_tready   | m_tdata, m_tuser: lux_valid
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_index (register), cfg_data
//
// An item that does not close a measurement is accumulated and then loaded; a closing one
// is accumulated and averaged by reciprocal multiply, then check, multiply, a serial divide
// of the lux numerator by rf, finish and load. Overrange skips to the load; rf 0 skips the divide.
// Reset is synchronous, active low; config returns to defaults, range to high gain.
// The output register holds one result; the next item is accepted while it waits,
// and that item stalls before its own result load until m_tready frees the register.
`timescale 1ns / 1ps

module autorange_light_meter #(
    parameter int SAMPLES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [alm_pkg::S_TDATA_W-1:0]     s_tdata,   // [11:0] sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] range_low, [16:1] lux, [17] saturated, [18] used_low_range
    output logic [alm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tuser,   // [0] lux_valid
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [alm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [alm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import alm_pkg::*;

    alm_cmd_t    cmd;
    alm_status_t status;

    assign cfg_ready = 1'b1;

    alm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    alm_datapath #(
        .SAMPLES (SAMPLES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* sim/tb_autorange_light_meter.sv */
// Self-checking testbench for autorange_light_meter: streams converter samples,
// predicts range drive and lux per transaction, checks every result. Uses alm_pkg.
`timescale 1ns / 1ps

module tb_autorange_light_meter;
    import alm_pkg::*;

    localparam int SAMPLES     = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 100;

    typedef struct packed {
        logic             range_low;
        logic             lux_valid;
        logic [LUX_W-1:0] lux;
        logic             saturated;
        logic             used_low_range;
    } meter_result_t;

    typedef enum int {PAT_FLAT, PAT_JITTER, PAT_NOISE} pattern_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // predictor copy of the registers and the measurement state
    logic [SAMPLE_W-1:0] reg_offset      = OFFSET_RST;
    logic [SAMPLE_W-1:0] reg_max_reading = MAX_READING_RST;
    logic [RF_W-1:0]     reg_rf_high     = RF_HIGH_RST;
    logic [RF_W-1:0]     reg_rf_low      = RF_LOW_RST;
    logic [GAIN_W-1:0]   reg_gain        = GAIN_RST;
    logic                meter_low_gain  = 1'b0;
    logic [8:0]          meter_count     = '0;
    logic [19:0]         meter_sum       = '0;

    meter_result_t lux_q[$];
    int  mismatch_cnt = 0;
    int  cycle_cnt    = 0;
    bit  gaps_on      = 1'b1;
    int  hold_req     = 0;
    int  stall_left   = 0;
    bit  s_held       = 1'b0;
    bit  cfg_held     = 1'b0;

    autorange_light_meter #(.SAMPLES(SAMPLES)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_OFFSET:      reg_offset      = val[SAMPLE_W-1:0];
            REG_MAX_READING: reg_max_reading = val[SAMPLE_W-1:0];
            REG_RF_HIGH:     reg_rf_high     = val[RF_W-1:0];
            REG_RF_LOW:      reg_rf_low      = val[RF_W-1:0];
            REG_GAIN:        reg_gain        = val[GAIN_W-1:0];
            default: ;       // unused index: write dropped
        endcase
    endfunction

    function automatic meter_result_t advance_meter(input logic [SAMPLE_W-1:0] smp);
        meter_result_t r;
        logic [63:0]   avg, net, product, quotient;
        logic [RF_W-1:0] rf;
        r = '0;
        meter_sum   = meter_sum + 20'(smp);
        meter_count = meter_count + 9'd1;
        if (meter_count >= SAMPLES) begin
            avg = 64'(meter_sum) / SAMPLES;
            meter_sum   = '0;
            meter_count = '0;
            if (!meter_low_gain && avg > 64'(reg_max_reading)) begin
                meter_low_gain = 1'b1;
            end else begin
                rf  = meter_low_gain ? reg_rf_low : reg_rf_high;
                net = (avg > 64'(reg_offset)) ? avg - 64'(reg_offset) : 64'd0;
                product = net * 64'(UV_PER_COUNT) * 64'(reg_gain);
                if (rf == '0) begin
                    r.lux       = LUX_MAX;
                    r.saturated = 1'b1;
                end else begin
                    quotient = product / (64'(rf) << 16);
                    if (quotient > 64'(LUX_MAX)) begin
                        r.lux       = LUX_MAX;
                        r.saturated = 1'b1;
                    end else begin
                        r.lux = quotient[LUX_W-1:0];
                    end
                end
                r.lux_valid      = 1'b1;
                r.used_low_range = meter_low_gain;
                meter_low_gain   = 1'b0;
            end
        end
        r.range_low = meter_low_gain;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------
    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input int typ_lo, input int typ_hi,
                                                             input int full_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return CFG_DATA_W'($urandom_range(typ_lo, typ_hi));
        if (r < 95) return CFG_DATA_W'($urandom_range(0, full_max));
        return (r < 97) ? '0 : CFG_DATA_W'(full_max);
    endfunction

    function automatic int pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(0, 4095);
        if (r < 65) return int'(reg_max_reading) + int'($urandom_range(0, 16)) - 8;
        if (r < 80) return int'(reg_offset) + int'($urandom_range(0, 16)) - 8;
        if (r < 90) return $urandom_range(3900, 4095);
        return $urandom_range(0, 63);
    endfunction

    function automatic logic [SAMPLE_W-1:0] make_sample(input pattern_t pat, input int level);
        int v;
        case (pat)
            PAT_FLAT:   v = level;
            PAT_JITTER: v = level + int'($urandom_range(0, 64)) - 32;
            default:    v = $urandom_range(0, 4095);
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return SAMPLE_W'(v);
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            if (s_held) s_tvalid <= 1'b0;
            s_held = 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(smp);
        s_held = 1'b1;
        do @(posedge aclk); while (!s_tready);
        lux_q.push_back(advance_meter(smp));
    endtask

    task automatic send_samples(input pattern_t pat, input int level, input int count);
        for (int i = 0; i < count; i++) send_sample(make_sample(pat, level));
    endtask

    task automatic send_measurement(input pattern_t pat, input int level);
        send_samples(pat, level, SAMPLES);
    endtask

    // sender stops and every expected result comes back
    task automatic drain();
        if (s_held) s_tvalid <= 1'b0;
        s_held = 1'b0;
        while (lux_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                             input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            if (cfg_held) cfg_valid <= 1'b0;
            cfg_held = 1'b0;
            repeat (gap) @(posedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_held = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
        if (last) begin
            cfg_valid <= 1'b0;
            cfg_held = 1'b0;
        end
    endtask

    task automatic write_all_regs(input logic [CFG_DATA_W-1:0] offset_v,
                                  input logic [CFG_DATA_W-1:0] max_v,
                                  input logic [CFG_DATA_W-1:0] rf_high_v,
                                  input logic [CFG_DATA_W-1:0] rf_low_v,
                                  input logic [CFG_DATA_W-1:0] gain_v);
        drain();
        write_reg(REG_OFFSET,      offset_v,  1'b0);
        write_reg(REG_MAX_READING, max_v,     1'b0);
        write_reg(REG_RF_HIGH,     rf_high_v, 1'b0);
        write_reg(REG_RF_LOW,      rf_low_v,  1'b0);
        write_reg(REG_GAIN,        gain_v,    1'b1);
    endtask

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            stall_left = hold_req;
            hold_req   = 0;
        end else if (stall_left == 0) begin
            stall_left = pick_gap();
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        meter_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (lux_q.size() == 0) begin
                $error("result transaction with no expectation pending: tdata %h tuser %b",
                       m_tdata, m_tuser);
                mismatch_cnt++;
            end else begin
                want = lux_q.pop_front();
                if (m_tdata[0] !== want.range_low) begin
                    $error("range_low: expected %0d, got %0d", want.range_low, m_tdata[0]);
                    mismatch_cnt++;
                end
                if (m_tuser !== want.lux_valid) begin
                    $error("lux_valid: expected %0d, got %0d", want.lux_valid, m_tuser);
                    mismatch_cnt++;
                end
                if (m_tdata[16:1] !== want.lux) begin
                    $error("lux: expected %0d, got %0d", want.lux, m_tdata[16:1]);
                    mismatch_cnt++;
                end
                if (m_tdata[17] !== want.saturated) begin
                    $error("saturated: expected %0d, got %0d", want.saturated, m_tdata[17]);
                    mismatch_cnt++;
                end
                if (m_tdata[18] !== want.used_low_range) begin
                    $error("used_low_range: expected %0d, got %0d", want.used_low_range,
                           m_tdata[18]);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     lux_q.size());
            $display("** autorange_light_meter: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset settings: dark floor, threshold edge, range switch, low-gain saturation, jitter, noise
    task automatic test_range_switching();
        send_measurement(PAT_FLAT, 0);
        send_measurement(PAT_FLAT, int'(MAX_READING_RST));
        send_measurement(PAT_FLAT, int'(MAX_READING_RST) + 1);
        send_measurement(PAT_FLAT, 4095);
        send_measurement(PAT_JITTER, 2000);
        send_measurement(PAT_NOISE, 0);
    endtask

    task automatic test_special_cases();
        // zero feedback resistance in either range
        drain();
        write_reg(REG_RF_HIGH, '0, 1'b0);
        write_reg(REG_RF_LOW,  '0, 1'b1);
        send_measurement(PAT_FLAT, 1000);
        send_measurement(PAT_FLAT, 4095);
        send_measurement(PAT_FLAT, 1000);
        // unused indexes must not disturb any register
        drain();
        write_reg(REG_RF_HIGH, CFG_DATA_W'(RF_HIGH_RST), 1'b0);
        write_reg(REG_RF_LOW,  CFG_DATA_W'(RF_LOW_RST),  1'b0);
        for (int i = int'(REG_GAIN) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom), i == (1 << CFG_IDX_W) - 1);
        send_measurement(PAT_FLAT, 1000);
        // registers change while a measurement is half done
        send_samples(PAT_JITTER, 3000, 7);
        drain();
        write_reg(REG_OFFSET,      CFG_DATA_W'(100),  1'b0);
        write_reg(REG_MAX_READING, CFG_DATA_W'(2500), 1'b1);
        send_samples(PAT_JITTER, 3000, 9);
        send_measurement(PAT_FLAT, 1500);
    endtask

    task automatic test_config_extremes();
        write_all_regs('0, 24'd4095, 24'd1, 24'd1, '1);
        repeat (3) send_measurement(PAT_JITTER, pick_level());
        write_all_regs(24'd4095, '0, '1, '1, '0);
        repeat (3) send_measurement(PAT_JITTER, pick_level());
        write_all_regs('0, '0, '1, 24'd1, '1);
        repeat (3) send_measurement(PAT_JITTER, pick_level());
        write_all_regs('0, 24'd4095, '1, '1, '1);
        repeat (3) send_measurement(PAT_NOISE, 0);
    endtask

    // receiver holds off while samples keep coming, so the input stalls
    task automatic test_backpressure();
        write_all_regs(CFG_DATA_W'(OFFSET_RST), CFG_DATA_W'(MAX_READING_RST),
                       CFG_DATA_W'(RF_HIGH_RST), CFG_DATA_W'(RF_LOW_RST), CFG_DATA_W'(GAIN_RST));
        gaps_on  = 1'b0;
        hold_req = 300;
        repeat (3) send_measurement(PAT_JITTER, pick_level());
        drain();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int count;
        int n;
        for (int phase = 0; phase < 6; phase++) begin
            write_all_regs(pick_reg_value(0, 100, 4095),
                           pick_reg_value(3000, 4095, 4095),
                           pick_reg_value(20000, 2000000, 24'hFFFFFF),
                           pick_reg_value(100, 20000, 24'hFFFFFF),
                           pick_reg_value(400000, 1500000, 24'hFFFFFF));
            gaps_on = (phase != 2);
            // odd lengths leave a measurement open across the register writes
            count = SAMPLES * $urandom_range(10, 14) + $urandom_range(0, SAMPLES - 1);
            while (count > 0) begin
                n = (count < SAMPLES) ? count : SAMPLES;
                send_samples(pattern_t'($urandom_range(0, 2)), pick_level(), n);
                count -= n;
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic finish_run();
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("** autorange_light_meter: PASSED **");
        end else begin
            $display("** autorange_light_meter: FAILED **");
        end
        $finish;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_range_switching();
        test_special_cases();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();
        finish_run();
    end

endmodule
